@@ sv/fcdma_pkg.sv @@
// ----------------------------------------------------------------------------
// fcdma_pkg
// Shared types and constants of the four-channel DMA controller.
// ----------------------------------------------------------------------------
package fcdma_pkg;

  localparam int unsigned NUM_CHAN      = 4;
  localparam logic [1:0]  STARTUP_DELAY = 2'd2;
  localparam logic [16:0] FIFO_BURST    = 17'd4;
  localparam logic [31:0] FIFO_A_ADDR   = 32'h0400_00A0;
  localparam logic [31:0] FIFO_B_ADDR   = 32'h0400_00A4;
  localparam logic [31:0] EWRAM_BASE    = 32'h0200_0000;

  // item functions
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_TRIG  = 2'd2;
  localparam logic [1:0] FN_TICK  = 2'd3;

  // trigger occasions
  localparam logic [2:0] OCC_HBLANK = 3'd0;
  localparam logic [2:0] OCC_VBLANK = 3'd1;
  localparam logic [2:0] OCC_VIDEO  = 3'd2;
  localparam logic [2:0] OCC_FIFO_A = 3'd3;
  localparam logic [2:0] OCC_FIFO_B = 3'd4;
  localparam logic [2:0] OCC_STOP   = 3'd5;

  // start timing codes
  localparam logic [1:0] TM_IMM     = 2'd0;
  localparam logic [1:0] TM_VBLANK  = 2'd1;
  localparam logic [1:0] TM_HBLANK  = 2'd2;
  localparam logic [1:0] TM_SPECIAL = 2'd3;

  // address control codes
  localparam logic [1:0] AC_INC    = 2'd0;
  localparam logic [1:0] AC_DEC    = 2'd1;
  localparam logic [1:0] AC_FIXED  = 2'd2;
  localparam logic [1:0] AC_RELOAD = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] chan_sel;
    logic [3:0] reg_offset;
    logic [7:0] wdata;
    logic [2:0] occasion;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        xfer_valid;
    logic [1:0]  xfer_channel;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic        word_unit;
    logic        skip_read;
    logic        sequential;
    logic        block_done;
    logic        irq_raise;
  } out_item_t;

  function automatic logic [31:0] src_mask(input logic [1:0] c);
    return (c == 2'd0) ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
  endfunction

  function automatic logic [31:0] dst_mask(input logic [1:0] c);
    return (c == 2'd3) ? 32'h0FFF_FFFF : 32'h07FF_FFFF;
  endfunction

  function automatic logic [15:0] len_mask(input logic [1:0] c);
    return (c == 2'd3) ? 16'hFFFF : 16'h3FFF;
  endfunction

endpackage

@@ sv/fcdma_if.sv @@
// ----------------------------------------------------------------------------
// fcdma_in_if / fcdma_out_if
// Valid/ready channels carrying command and result items.
// ----------------------------------------------------------------------------
interface fcdma_in_if;
  logic                 valid;
  logic                 ready;
  fcdma_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fcdma_out_if;
  logic                 valid;
  logic                 ready;
  fcdma_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/four_channel_dma_controller.sv @@
// ----------------------------------------------------------------------------
// four_channel_dma_controller
// Four-channel fixed-priority DMA sequencer: register access, triggers, ticks.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  in_     | sink      | func, chan_sel, reg_offset, wdata, occasion
//  out_    | source    | rdata and one transfer unit description
//
// One item per cycle: each accepted item updates channel state and loads the
// result register in the same cycle. The result register is the only stage;
// a new item is taken whenever it is empty or being drained. Reset clears all
// channel state; out_valid drops. A stalled output holds its item and stops
// input acceptance until it is taken.
module four_channel_dma_controller (
  input  logic          clk,
  input  logic          rst_n,
  fcdma_in_if.sink      in_ch,
  fcdma_out_if.source   out_ch
);

  logic [27:0] reg_source_r [4];
  logic [27:0] reg_dest_r   [4];
  logic [15:0] reg_count_r  [4];
  logic [12:0] ctrl_bits_r  [4];
  logic [31:0] cur_source_r [4];
  logic [31:0] cur_dest_r   [4];
  logic [16:0] cur_rem_r    [4];
  logic [3:0]  fifo_mode_r;
  logic [1:0]  startup_r    [4];
  logic [3:0]  hb_mask_r, vb_mask_r, vid_mask_r, run_mask_r;
  logic [2:0]  active_r;
  logic        seq_r;

  logic [27:0] reg_source_nxt [4];
  logic [27:0] reg_dest_nxt   [4];
  logic [15:0] reg_count_nxt  [4];
  logic [12:0] ctrl_bits_nxt  [4];
  logic [31:0] cur_source_nxt [4];
  logic [31:0] cur_dest_nxt   [4];
  logic [16:0] cur_rem_nxt    [4];
  logic [3:0]  fifo_mode_nxt;
  logic [1:0]  startup_nxt    [4];
  logic [3:0]  hb_mask_nxt, vb_mask_nxt, vid_mask_nxt, run_mask_nxt;
  logic [2:0]  active_nxt;
  logic        seq_nxt;

  logic                 out_valid_r;
  fcdma_pkg::out_item_t out_item_r, res;
  logic                 accept;

  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  // first runnable channel, 4 when none
  function automatic logic [2:0] first_of(input logic [3:0] m);
    logic [2:0] r;
    r = 3'd4;
    for (int i = 3; i >= 0; i--) if (m[i]) r = 3'(i);
    return r;
  endfunction

  // next-state logic for one item
  always_comb begin
    fcdma_pkg::in_item_t it;
    logic [1:0]  c, ac;
    logic [31:0] v32, sh32, hm, page, lm;
    logic [7:0]  v;
    logic [12:0] ct;
    logic        was, word;
    logic [31:0] step, sm, dm;
    logic [16:0] n, rem;
    it = in_ch.payload;
    c  = it.chan_sel;
    reg_source_nxt = reg_source_r; reg_dest_nxt = reg_dest_r;
    reg_count_nxt = reg_count_r; ctrl_bits_nxt = ctrl_bits_r;
    cur_source_nxt = cur_source_r; cur_dest_nxt = cur_dest_r;
    cur_rem_nxt = cur_rem_r; fifo_mode_nxt = fifo_mode_r;
    startup_nxt = startup_r;
    hb_mask_nxt = hb_mask_r; vb_mask_nxt = vb_mask_r;
    vid_mask_nxt = vid_mask_r; run_mask_nxt = run_mask_r;
    active_nxt = active_r; seq_nxt = seq_r;
    res = '0;
    v = it.wdata;
    v32 = '0; sh32 = '0; hm = '0; page = '0; lm = '0; ct = '0; was = 1'b0;
    word = 1'b0; step = '0; sm = '0; dm = '0; n = '0; rem = '0; ac = '0;
    case (it.func)
      fcdma_pkg::FN_WRITE: begin
        if (it.reg_offset <= 4'd7) begin
          sh32 = {24'd0, v} << {it.reg_offset[1:0], 3'b000};
          hm   = 32'hFF << {it.reg_offset[1:0], 3'b000};
          if (!it.reg_offset[2]) begin
            v32 = ({4'd0, reg_source_r[c]} & ~hm) | (sh32 & fcdma_pkg::src_mask(c));
            reg_source_nxt[c] = v32[27:0];
          end else begin
            v32 = ({4'd0, reg_dest_r[c]} & ~hm) | (sh32 & fcdma_pkg::dst_mask(c));
            reg_dest_nxt[c] = v32[27:0];
          end
        end else if (it.reg_offset == 4'd8) begin
          reg_count_nxt[c] = {reg_count_r[c][15:8], v};
        end else if (it.reg_offset == 4'd9) begin
          reg_count_nxt[c] = {v, reg_count_r[c][7:0]};
        end else if (it.reg_offset == 4'd10) begin
          // only the top three bits of the low control byte are kept
          ctrl_bits_nxt[c] = {ctrl_bits_r[c][12:5], v[7:5], 2'b00};
        end else if (it.reg_offset == 4'd11) begin
          was = ctrl_bits_r[c][12];
          if (v[5:4] == fcdma_pkg::TM_IMM) v[1] = 1'b0;
          if (c != 2'd3) v[3] = 1'b0;
          ct = {v, ctrl_bits_r[c][4:2], 2'b00};
          ctrl_bits_nxt[c] = ct;
          hb_mask_nxt[c] = 1'b0; vb_mask_nxt[c] = 1'b0; vid_mask_nxt[c] = 1'b0;
          if (!ct[12]) begin
            run_mask_nxt[c] = 1'b0;
            startup_nxt[c]  = 2'd0;
            if ({1'b0, c} == active_r) begin
              active_nxt = first_of(run_mask_nxt);
              seq_nxt = 1'b0;
            end
          end else begin
            if (ct[10:9] == fcdma_pkg::TM_HBLANK) hb_mask_nxt[c] = 1'b1;
            else if (ct[10:9] == fcdma_pkg::TM_VBLANK) vb_mask_nxt[c] = 1'b1;
            else if (ct[10:9] == fcdma_pkg::TM_SPECIAL && c == 2'd3) vid_mask_nxt[3] = 1'b1;
            if (!was) begin
              page = {28'd0, reg_source_r[c][27:24]};
              if (page >= 32'h08 && page <= 32'h0D) ct[5:4] = fcdma_pkg::AC_INC;
              if (ct[10:9] == fcdma_pkg::TM_SPECIAL && (c == 2'd1 || c == 2'd2)) begin
                fifo_mode_nxt[c] = 1'b1;
                ct[7] = 1'b1;
                cur_rem_nxt[c] = fcdma_pkg::FIFO_BURST;
                cur_source_nxt[c] = {4'd0, reg_source_r[c][27:2], 2'b00};
                cur_dest_nxt[c]   = {4'd0, reg_dest_r[c][27:2], 2'b00};
              end else begin
                fifo_mode_nxt[c] = 1'b0;
                lm = ct[7] ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
                cur_source_nxt[c] = {4'd0, reg_source_r[c]} & lm;
                cur_dest_nxt[c]   = {4'd0, reg_dest_r[c]} & lm;
                n = {1'b0, reg_count_r[c] & fcdma_pkg::len_mask(c)};
                cur_rem_nxt[c] = (n != 17'd0) ? n
                               : {1'b0, fcdma_pkg::len_mask(c)} + 17'd1;
                if (ct[10:9] == fcdma_pkg::TM_IMM) startup_nxt[c] = fcdma_pkg::STARTUP_DELAY;
              end
              ctrl_bits_nxt[c] = ct;
            end
          end
        end
      end
      fcdma_pkg::FN_READ: begin
        if (it.reg_offset == 4'd10) res.rdata = {ctrl_bits_r[c][4:0], 3'b000};
        else if (it.reg_offset == 4'd11) res.rdata = ctrl_bits_r[c][12:5];
      end
      fcdma_pkg::FN_TRIG: begin
        case (it.occasion)
          fcdma_pkg::OCC_HBLANK:
            for (int i = 0; i < 4; i++) if (hb_mask_r[i]) startup_nxt[i] = fcdma_pkg::STARTUP_DELAY;
          fcdma_pkg::OCC_VBLANK:
            for (int i = 0; i < 4; i++) if (vb_mask_r[i]) startup_nxt[i] = fcdma_pkg::STARTUP_DELAY;
          fcdma_pkg::OCC_VIDEO:
            for (int i = 0; i < 4; i++) if (vid_mask_r[i]) startup_nxt[i] = fcdma_pkg::STARTUP_DELAY;
          fcdma_pkg::OCC_FIFO_A, fcdma_pkg::OCC_FIFO_B: begin
            v32 = (it.occasion == fcdma_pkg::OCC_FIFO_A) ? fcdma_pkg::FIFO_A_ADDR
                                                         : fcdma_pkg::FIFO_B_ADDR;
            for (int i = 1; i <= 2; i++)
              if (ctrl_bits_r[i][12] && ctrl_bits_r[i][10:9] == fcdma_pkg::TM_SPECIAL
                  && {4'd0, reg_dest_r[i]} == v32)
                startup_nxt[i] = fcdma_pkg::STARTUP_DELAY;
          end
          fcdma_pkg::OCC_STOP: begin
            if (ctrl_bits_r[3][12] && ctrl_bits_r[3][10:9] == fcdma_pkg::TM_SPECIAL) begin
              ctrl_bits_nxt[3][12] = 1'b0;
              run_mask_nxt[3] = 1'b0;
              vid_mask_nxt[3] = 1'b0;
              startup_nxt[3] = 2'd0;
              active_nxt = first_of(run_mask_nxt);
              seq_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: begin
        // startup countdown, lowest channel first
        for (int i = 0; i < 4; i++) begin
          if (startup_r[i] != 2'd0) begin
            startup_nxt[i] = startup_r[i] - 2'd1;
            if (startup_nxt[i] == 2'd0) begin
              if (run_mask_nxt == 4'd0 || 3'(i) < active_nxt) begin
                if (3'(i) != active_nxt) seq_nxt = 1'b0;
                active_nxt = 3'(i);
              end
              run_mask_nxt[i] = 1'b1;
            end
          end
        end
        // one unit of the active channel
        if (!active_nxt[2]) begin
          ac = active_nxt[1:0];
          ct = ctrl_bits_r[ac];
          rem = cur_rem_r[ac];
          if (rem != 17'd0) begin
            word = fifo_mode_r[ac] | ct[7];
            step = word ? 32'd4 : 32'd2;
            sm = (ct[5:4] == fcdma_pkg::AC_INC) ? step :
                 (ct[5:4] == fcdma_pkg::AC_DEC) ? (32'd0 - step) : 32'd0;
            dm = fifo_mode_r[ac] ? 32'd0 :
                 (ct[3:2] == fcdma_pkg::AC_INC || ct[3:2] == fcdma_pkg::AC_RELOAD) ? step :
                 (ct[3:2] == fcdma_pkg::AC_DEC) ? (32'd0 - step) : 32'd0;
            res.xfer_valid   = 1'b1;
            res.xfer_channel = ac;
            res.src_address  = cur_source_r[ac];
            res.dst_address  = cur_dest_r[ac];
            res.word_unit    = word;
            res.skip_read    = cur_source_r[ac] < fcdma_pkg::EWRAM_BASE;
            res.sequential   = seq_nxt;
            cur_source_nxt[ac] = cur_source_r[ac] + sm;
            cur_dest_nxt[ac]   = cur_dest_r[ac] + dm;
            rem = rem - 17'd1;
            cur_rem_nxt[ac] = rem;
            seq_nxt = 1'b1;
          end
          // block end
          if (rem == 17'd0) begin
            res.block_done = res.xfer_valid;
            run_mask_nxt[ac] = 1'b0;
            res.irq_raise = ct[11] & res.xfer_valid;
            if (ct[6]) begin
              if (fifo_mode_r[ac]) begin
                cur_rem_nxt[ac] = fcdma_pkg::FIFO_BURST;
              end else begin
                n = {1'b0, reg_count_r[ac] & fcdma_pkg::len_mask(ac)};
                cur_rem_nxt[ac] = (n != 17'd0) ? n
                                : {1'b0, fcdma_pkg::len_mask(ac)} + 17'd1;
                if (ct[3:2] == fcdma_pkg::AC_RELOAD)
                  cur_dest_nxt[ac] = {4'd0, reg_dest_r[ac]} &
                                     (ct[7] ? 32'hFFFF_FFFC : 32'hFFFF_FFFE);
              end
            end else begin
              ctrl_bits_nxt[ac][12] = 1'b0;
              hb_mask_nxt[ac] = 1'b0; vb_mask_nxt[ac] = 1'b0; vid_mask_nxt[ac] = 1'b0;
            end
            active_nxt = first_of(run_mask_nxt);
            seq_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        reg_source_r[i] <= '0; reg_dest_r[i] <= '0; reg_count_r[i] <= '0;
        ctrl_bits_r[i] <= '0; cur_source_r[i] <= '0; cur_dest_r[i] <= '0;
        cur_rem_r[i] <= '0; startup_r[i] <= '0;
      end
      fifo_mode_r <= '0;
      hb_mask_r <= '0; vb_mask_r <= '0; vid_mask_r <= '0; run_mask_r <= '0;
      active_r <= 3'd4;
      seq_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        reg_source_r <= reg_source_nxt; reg_dest_r <= reg_dest_nxt;
        reg_count_r <= reg_count_nxt; ctrl_bits_r <= ctrl_bits_nxt;
        cur_source_r <= cur_source_nxt; cur_dest_r <= cur_dest_nxt;
        cur_rem_r <= cur_rem_nxt; fifo_mode_r <= fifo_mode_nxt;
        startup_r <= startup_nxt;
        hb_mask_r <= hb_mask_nxt; vb_mask_r <= vb_mask_nxt;
        vid_mask_r <= vid_mask_nxt; run_mask_r <= run_mask_nxt;
        active_r <= active_nxt; seq_r <= seq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_item_r <= res;
  end

  // checks
  a_active_runnable: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r[2] |-> run_mask_r[active_r[1:0]])
    else $error("active channel not runnable");
  a_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
    (run_mask_r == 4'd0) |-> active_r[2])
    else $error("active channel with empty runnable set");
  a_done_needs_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.block_done || out_item_r.irq_raise) |-> out_item_r.xfer_valid)
    else $error("block end mark without a unit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_item_r))
    else $error("stalled result changed");

endmodule
